// File: sv/sha1d_pkg.sv
// shared types, constants and helpers for the sha-1 digest block
package sha1d_pkg;

  localparam int unsigned WordCount   = 5;
  localparam int unsigned SchedWords  = 16;
  localparam int unsigned RoundCount  = 80;
  localparam int unsigned RoundW      = $clog2(RoundCount);
  localparam int unsigned WordIdxW    = 3;
  localparam logic [7:0]  PadByte     = 8'h80;
  localparam logic [5:0]  LenPos      = 6'd56;
  localparam logic [5:0]  LastPos     = 6'd63;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       msg_end;
  } sha1d_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        digest_done;
  } sha1d_out_t;

  typedef enum logic [1:0] {
    SRC_IN   = 2'd0,
    SRC_PAD  = 2'd1,
    SRC_ZERO = 2'd2
  } byte_src_e;

  typedef struct packed {
    logic              put;
    byte_src_e         put_src;
    logic              count_bits;
    logic              len_we;
    logic              work_load;
    logic              round_en;
    logic [RoundW-1:0] rnd;
    logic              chain_add;
    logic              out_load;
    logic              restart;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] byte_cnt;
    logic       out_free;
  } dp_sts_t;

  function automatic logic [31:0] iv_word(input logic [WordIdxW-1:0] idx);
    logic [31:0] w;
    unique case (idx)
      3'd0:    w = 32'h67452301;
      3'd1:    w = 32'hEFCDAB89;
      3'd2:    w = 32'h98BADCFE;
      3'd3:    w = 32'h10325476;
      3'd4:    w = 32'hC3D2E1F0;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] round_k(input logic [1:0] grp);
    logic [31:0] k;
    unique case (grp)
      2'd0: k = 32'h5A827999;
      2'd1: k = 32'h6ED9EBA1;
      2'd2: k = 32'h8F1BBCDC;
      2'd3: k = 32'hCA62C1D6;
    endcase
    return k;
  endfunction

endpackage

// File: sv/sha1d_ctrl.sv
// sequencer for byte loading, padding, compression rounds and digest read-out
module sha1d_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              byte_present_i,
  input  logic              msg_end_i,
  input  sha1d_pkg::dp_sts_t sts_i,
  output sha1d_pkg::dp_cmd_t cmd_o
);
  import sha1d_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOAD  = 9'b000000010,
    S_ROUND = 9'b000000100,
    S_ADD   = 9'b000001000,
    S_PAD80 = 9'b000010000,
    S_ZERO1 = 9'b000100000,
    S_ZERO2 = 9'b001000000,
    S_LEN   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  typedef enum logic [1:0] {
    NX_IDLE  = 2'd0,
    NX_PAD   = 2'd1,
    NX_ZERO2 = 2'd2,
    NX_OUT   = 2'd3
  } after_e;

  state_e            state_q, state_d;
  after_e            after_q, after_d;
  logic [RoundW-1:0] rnd_q, rnd_d;
  logic              accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    after_d = after_q;
    rnd_d   = rnd_q;
    cmd_o   = '0;
    cmd_o.put_src = SRC_IN;
    cmd_o.rnd     = rnd_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (byte_present_i) begin
            cmd_o.put        = 1'b1;
            cmd_o.count_bits = 1'b1;
          end
          if (byte_present_i && sts_i.byte_cnt == LastPos) begin
            state_d = S_LOAD;
            after_d = msg_end_i ? NX_PAD : NX_IDLE;
          end else if (msg_end_i) begin
            state_d = S_PAD80;
          end
        end
      end
      S_LOAD: begin
        cmd_o.work_load = 1'b1;
        rnd_d   = '0;
        state_d = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.round_en = 1'b1;
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == RoundW'(RoundCount - 1)) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.chain_add = 1'b1;
        rnd_d = '0;
        unique case (after_q)
          NX_IDLE:  state_d = S_IDLE;
          NX_PAD:   state_d = S_PAD80;
          NX_ZERO2: state_d = S_ZERO2;
          NX_OUT:   state_d = S_OUT;
        endcase
      end
      S_PAD80: begin
        cmd_o.put     = 1'b1;
        cmd_o.put_src = SRC_PAD;
        priority if (sts_i.byte_cnt == LastPos) begin
          state_d = S_LOAD;
          after_d = NX_ZERO2;
        end else if (sts_i.byte_cnt >= LenPos) begin
          state_d = S_ZERO1;
        end else begin
          state_d = S_ZERO2;
        end
      end
      S_ZERO1: begin
        cmd_o.put     = 1'b1;
        cmd_o.put_src = SRC_ZERO;
        if (sts_i.byte_cnt == LastPos) begin
          state_d = S_LOAD;
          after_d = NX_ZERO2;
        end
      end
      S_ZERO2: begin
        if (sts_i.byte_cnt == LenPos) begin
          state_d = S_LEN;
        end else begin
          cmd_o.put     = 1'b1;
          cmd_o.put_src = SRC_ZERO;
        end
      end
      S_LEN: begin
        cmd_o.len_we = 1'b1;
        state_d = S_LOAD;
        after_d = NX_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          rnd_d = rnd_q + 1'b1;
          if (rnd_q == RoundW'(WordCount - 1)) begin
            cmd_o.restart = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      after_q <= NX_IDLE;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
      rnd_q   <= rnd_d;
    end
  end

endmodule

// File: sv/sha1d_dp.sv
// message window, round registers, chaining value, length count and output register
module sha1d_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           msg_byte_i,
  input  sha1d_pkg::dp_cmd_t   cmd_i,
  output sha1d_pkg::dp_sts_t   sts_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sha1d_pkg::sha1d_out_t out_data_o
);
  import sha1d_pkg::*;

  logic [31:0] win_q   [SchedWords];
  logic [31:0] work_q  [WordCount];
  logic [31:0] chain_q [WordCount];
  logic [5:0]  cnt_q;
  logic [63:0] bits_q;
  logic        out_valid_q;
  sha1d_out_t  out_q;

  logic [7:0]          put_byte;
  logic [3:0]          put_idx;
  logic [1:0]          put_lane;
  logic [31:0]         w_mix;
  logic [31:0]         w_cur;
  logic [1:0]          grp;
  logic [31:0]         f_val;
  logic [31:0]         t_val;
  logic [WordIdxW-1:0] oidx;

  always_comb begin
    unique case (cmd_i.put_src)
      SRC_IN:   put_byte = msg_byte_i;
      SRC_PAD:  put_byte = PadByte;
      default:  put_byte = 8'h00;
    endcase
  end

  assign put_idx  = cnt_q[5:2];
  assign put_lane = cnt_q[1:0];

  assign w_mix = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
  assign w_cur = (cmd_i.rnd < RoundW'(SchedWords)) ? win_q[0] : {w_mix[30:0], w_mix[31]};

  always_comb begin
    priority if (cmd_i.rnd < RoundW'(20)) grp = 2'd0;
    else if (cmd_i.rnd < RoundW'(40))     grp = 2'd1;
    else if (cmd_i.rnd < RoundW'(60))     grp = 2'd2;
    else                                  grp = 2'd3;
  end

  always_comb begin
    unique case (grp)
      2'd0:    f_val = (work_q[1] & work_q[2]) | (~work_q[1] & work_q[3]);
      2'd2:    f_val = (work_q[1] & work_q[2]) | (work_q[1] & work_q[3])
                     | (work_q[2] & work_q[3]);
      default: f_val = work_q[1] ^ work_q[2] ^ work_q[3];
    endcase
  end

  assign t_val = {work_q[0][26:0], work_q[0][31:27]} + f_val + work_q[4]
               + round_k(grp) + w_cur;

  // message window: byte writes, length words, schedule shift
  always_ff @(posedge clk_i) begin
    if (cmd_i.put) begin
      unique case (put_lane)
        2'd0: win_q[put_idx] <= {put_byte, 24'h0};
        2'd1: win_q[put_idx][23:16] <= put_byte;
        2'd2: win_q[put_idx][15:8]  <= put_byte;
        2'd3: win_q[put_idx][7:0]   <= put_byte;
      endcase
    end else if (cmd_i.len_we) begin
      win_q[14] <= bits_q[63:32];
      win_q[15] <= bits_q[31:0];
    end else if (cmd_i.round_en) begin
      for (int i = 0; i < SchedWords - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[SchedWords-1] <= w_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WordCount; i++) begin
        work_q[i]  <= '0;
        chain_q[i] <= iv_word(WordIdxW'(i));
      end
      cnt_q  <= '0;
      bits_q <= '0;
    end else begin
      if (cmd_i.restart) begin
        for (int i = 0; i < WordCount; i++) begin
          work_q[i]  <= '0;
          chain_q[i] <= iv_word(WordIdxW'(i));
        end
        cnt_q  <= '0;
        bits_q <= '0;
      end else begin
        if (cmd_i.put) begin
          cnt_q <= cnt_q + 6'd1;
        end
        if (cmd_i.count_bits) begin
          bits_q <= bits_q + 64'd8;
        end
        if (cmd_i.work_load) begin
          for (int i = 0; i < WordCount; i++) begin
            work_q[i] <= chain_q[i];
          end
        end else if (cmd_i.round_en) begin
          work_q[0] <= t_val;
          work_q[1] <= work_q[0];
          work_q[2] <= {work_q[1][1:0], work_q[1][31:2]};
          work_q[3] <= work_q[2];
          work_q[4] <= work_q[3];
        end
        if (cmd_i.chain_add) begin
          for (int i = 0; i < WordCount; i++) begin
            chain_q[i] <= chain_q[i] + work_q[i];
          end
        end
      end
    end
  end

  // digest output beat register
  assign oidx = cmd_i.rnd[WordIdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.digest_word <= chain_q[oidx];
      out_q.word_number <= oidx;
      out_q.digest_done <= (oidx == WordIdxW'(WordCount - 1));
    end
  end

  assign sts_o.byte_cnt = cnt_q;
  assign sts_o.out_free = ~out_valid_q | out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

// File: sv/sha1_digest_top.sv
// top level of the byte-serial sha-1 digest block
// a byte beat is taken while the sequencer is idle; the beat that fills a 64-byte
// block starts the load, 80 rounds of the single round unit and the chaining add
// the last beat starts the padding, the length write and one or two compressions,
// then five digest beats at up to one per cycle, as out_ready_i allows
// no bytes are taken while the shared round unit works on a block
// reset (async, active low) loads the initial vector and clears counts and control
module sha1_digest_top (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  sha1d_pkg::sha1d_in_t   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output sha1d_pkg::sha1d_out_t  out_data_o
);
  import sha1d_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  sha1d_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .byte_present_i (in_data_i.byte_present),
    .msg_end_i      (in_data_i.msg_end),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  sha1d_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .msg_byte_i  (in_data_i.msg_byte),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
